FILE: design/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, character codes and decode helpers for the string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // Decode modes of the front end
  localparam logic [1:0] MODE_PLAIN  = 2'd0;
  localparam logic [1:0] MODE_ESCAPE = 2'd1;
  localparam logic [1:0] MODE_HEX    = 2'd2;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_U   = 8'h75;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;

  // Last hex digit index of a \u group
  localparam logic [1:0] HEX_LAST = 2'd3;

  // One queued transaction group: up to three bytes, cnt == 0 is a bare end marker
  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      cnt;
    logic            last;
  } entry_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hexv_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] chr;
  } esc_t;

  function automatic hexv_t hex_value(input logic [7:0] c);
    hexv_t r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.ok  = 1'b1;
      r.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.ok  = 1'b1;
      r.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.ok  = 1'b1;
      r.val = 4'(c - 8'h37);
    end
    return r;
  endfunction

  function automatic esc_t map_escape(input logic [7:0] c);
    esc_t r;
    r.ok = 1'b1;
    unique case (c)
      CH_QUOTE:  r.chr = CH_QUOTE;
      CH_BSLASH: r.chr = CH_BSLASH;
      CH_SLASH:  r.chr = CH_SLASH;
      CH_LC_B:   r.chr = CH_BS;
      CH_LC_F:   r.chr = CH_FF;
      CH_LC_N:   r.chr = CH_LF;
      CH_LC_R:   r.chr = CH_CR;
      CH_LC_T:   r.chr = CH_TAB;
      default: begin
        r.ok  = 1'b0;
        r.chr = CH_NUL;
      end
    endcase
    return r;
  endfunction

  // UTF-8 encoding of a 16-bit code point; zero encodes to nothing
  function automatic entry_t utf8_encode(input logic [15:0] cp);
    entry_t r;
    r = '0;
    if (cp == 16'h0000) begin
      r.cnt = 2'd0;
    end else if (cp < 16'h0080) begin
      r.data[0] = cp[7:0];
      r.cnt     = 2'd1;
    end else if (cp < 16'h0800) begin
      r.data[0] = {3'b110, cp[10:6]};
      r.data[1] = {2'b10, cp[5:0]};
      r.cnt     = 2'd2;
    end else begin
      r.data[0] = {4'b1110, cp[15:12]};
      r.data[1] = {2'b10, cp[11:6]};
      r.data[2] = {2'b10, cp[5:0]};
      r.cnt     = 2'd3;
    end
    return r;
  endfunction

endpackage

FILE: design/jsu_in_if.sv
// ----------------------------------------------------------------------------
// jsu_in_if
// Input channel: one escaped byte per transaction, with an end-of-string flag.
// ----------------------------------------------------------------------------
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

FILE: design/jsu_out_if.sv
// ----------------------------------------------------------------------------
// jsu_out_if
// Result channel: one unescaped byte or a bare end marker per transaction.
// ----------------------------------------------------------------------------
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_last;

  modport source (output valid, output out_byte, output out_valid, output out_last,
                  input ready);
  modport sink   (input valid, input out_byte, input out_valid, input out_last,
                  output ready);
endinterface

FILE: design/jsu_fifo.sv
// ----------------------------------------------------------------------------
// jsu_fifo
// Small register queue of decoded groups between front end and back end.
// ----------------------------------------------------------------------------
module jsu_fifo
  import jsu_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_data,
  output logic   full,
  input  logic   pop,
  output entry_t head,
  output logic   empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // occupancy never exceeds the storage
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("jsu_fifo: occupancy above depth");

  // occupancy rises by one on a push without a pop
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("jsu_fifo: count did not follow a push");

endmodule

FILE: design/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Escape decoder: tracks escapes, queues groups, one byte/cycle unless q_full.
// ----------------------------------------------------------------------------
module jsu_front
  import jsu_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  jsu_in_if.sink  in_ch,
  input  logic    q_full,
  output logic    q_push,
  output entry_t  q_data
);

  logic [1:0]  mode_r, mode_nxt;
  logic [1:0]  digits_r, digits_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic        stop_r, stop_nxt;

  logic        accept;
  logic [7:0]  b;
  hexv_t       hv;
  esc_t        em;
  logic [15:0] acc_upd;
  logic        stop_upd;
  entry_t      grp;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign b           = in_ch.in_byte;
  assign hv          = hex_value(b);
  assign em          = map_escape(b);

  always_comb begin
    mode_nxt   = mode_r;
    digits_nxt = digits_r;
    acc_nxt    = acc_r;
    stop_nxt   = stop_r;
    acc_upd    = acc_r;
    stop_upd   = stop_r;
    grp        = '0;

    if (mode_r == MODE_HEX) begin
      if (!stop_r) begin
        if (hv.ok) begin
          acc_upd = {acc_r[11:0], hv.val};
        end else begin
          stop_upd = 1'b1;
        end
      end
      if (digits_r == HEX_LAST) begin
        grp        = utf8_encode(acc_upd);
        mode_nxt   = MODE_PLAIN;
        digits_nxt = '0;
        acc_nxt    = '0;
        stop_nxt   = 1'b0;
      end else begin
        digits_nxt = digits_r + 1'b1;
        acc_nxt    = acc_upd;
        stop_nxt   = stop_upd;
      end
    end else if (b != CH_NUL) begin
      if (mode_r == MODE_ESCAPE) begin
        if (b == CH_LC_U) begin
          mode_nxt   = MODE_HEX;
          digits_nxt = '0;
          acc_nxt    = '0;
          stop_nxt   = 1'b0;
        end else begin
          if (em.ok) begin
            grp.data[0] = em.chr;
            grp.cnt     = 2'd1;
          end
          mode_nxt = MODE_PLAIN;
        end
      end else if (b == CH_BSLASH) begin
        mode_nxt = MODE_ESCAPE;
      end else begin
        grp.data[0] = b;
        grp.cnt     = 2'd1;
      end
    end

    // end of string: drop any unfinished escape
    if (in_ch.in_last) begin
      mode_nxt   = MODE_PLAIN;
      digits_nxt = '0;
      acc_nxt    = '0;
      stop_nxt   = 1'b0;
    end
    grp.last = in_ch.in_last;
  end

  assign q_push = accept && ((grp.cnt != 2'd0) || in_ch.in_last);
  assign q_data = grp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_PLAIN;
      digits_r <= '0;
      acc_r    <= '0;
      stop_r   <= 1'b0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      digits_r <= digits_nxt;
      acc_r    <= acc_nxt;
      stop_r   <= stop_nxt;
    end
  end

  // a string end always leaves the decoder clean
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.in_last) |=> (mode_r == MODE_PLAIN && digits_r == '0 && acc_r == '0))
    else $error("jsu_front: state not cleared after end of string");

  // digit count only runs inside a \u group
  a_digits_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (digits_r != '0) |-> (mode_r == MODE_HEX))
    else $error("jsu_front: digit count outside hex mode");

endmodule

FILE: design/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Serializer: sends each queued group as one to three result transactions.
// ----------------------------------------------------------------------------
module jsu_back
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  entry_t     q_head,
  input  logic       q_empty,
  output logic       q_pop,
  jsu_out_if.source  out_ch
);

  logic [1:0] idx_r, idx_nxt;
  logic [1:0] final_idx;
  logic       xfer;
  logic [7:0] sel_byte;

  assign final_idx = (q_head.cnt == 2'd0) ? 2'd0 : q_head.cnt - 2'd1;
  assign xfer      = !q_empty && out_ch.ready;
  assign q_pop     = xfer && (idx_r == final_idx);

  always_comb begin
    case (idx_r)
      2'd0:    sel_byte = q_head.data[0];
      2'd1:    sel_byte = q_head.data[1];
      2'd2:    sel_byte = q_head.data[2];
      default: sel_byte = CH_NUL;
    endcase
  end

  assign out_ch.valid     = !q_empty;
  assign out_ch.out_valid = (q_head.cnt != 2'd0);
  assign out_ch.out_byte  = (q_head.cnt != 2'd0) ? sel_byte : CH_NUL;
  assign out_ch.out_last  = q_head.last && (idx_r == final_idx);

  always_comb begin
    idx_nxt = idx_r;
    if (xfer) begin
      idx_nxt = (idx_r == final_idx) ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  // byte index stays within the group at the head
  a_idx_in_group: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> (idx_r <= final_idx))
    else $error("jsu_back: byte index past end of group");

endmodule

FILE: design/json_string_unescape_top.sv
// ----------------------------------------------------------------------------
// json_string_unescape_top
// Streaming unescaper for the body of a JSON string value.
// ----------------------------------------------------------------------------
// The block takes one escaped byte per transaction on in_ch and returns the
// unescaped bytes on out_ch. Input is accepted at one byte per clock whenever
// the group queue has room; in_ch.ready never waits on out_ch.ready directly.
// Each input byte makes zero, one, two or three result transactions (three
// only for a \u code point at or above 0x800), and the back end sends one
// result per clock while the receiver is ready. A \u group takes six input
// bytes for at most three results, so no byte stream makes more results than
// it has bytes, and with the receiver always ready the input runs at one byte
// per cycle. The input stalls only when the FIFO_DEPTH-entry queue between
// decoder and serializer is full because the receiver is holding off. A
// result is held in the group queue, so it never leaves in the cycle in which
// its byte is taken. A byte that closes a string (in_last) always yields at
// least one result: if it produces no data, a bare end marker with out_valid
// low and out_last high is sent. There is no clearing pass after reset; a
// transaction can be accepted at the first clock edge with rst_n high.
// ----------------------------------------------------------------------------
module json_string_unescape_top
  import jsu_pkg::*;
#(
  parameter int FIFO_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  jsu_in_if.sink     in_ch,
  jsu_out_if.source  out_ch
);

  // Decoder to queue
  logic   q_push;
  entry_t q_data;
  logic   q_full;

  // Queue to serializer
  logic   q_pop;
  entry_t q_head;
  logic   q_empty;

  // Front end: escape decoding, one byte per cycle while the queue has room
  jsu_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_data)
  );

  // Group queue: decouples input acceptance from result back-pressure
  jsu_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // Back end: one result transaction per cycle while out_ch is ready
  jsu_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_head  (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for json_string_unescape_top. Escaped strings go in one
// byte per transaction. A decoder model in this file computes the unescaped
// bytes, or a pinned directed row gives its result directly, and every result
// transaction is compared against them, field by field and in order.
// ----------------------------------------------------------------------------
module testbench;
  import jsu_pkg::*;

  // Character codes that the package does not name
  localparam logic [7:0] DIG_0 = "0";
  localparam logic [7:0] DIG_9 = "9";
  localparam logic [7:0] LC_A  = "a";
  localparam logic [7:0] LC_F  = "f";
  localparam logic [7:0] LC_G  = "g";
  localparam logic [7:0] LC_Q  = "q";
  localparam logic [7:0] LC_Z  = "z";
  localparam logic [7:0] UC_A  = "A";
  localparam logic [7:0] UC_D  = "D";
  localparam logic [7:0] UC_F  = "F";
  localparam logic [7:0] DIG_1 = "1";

  localparam int NUM_ITEMS   = 300;
  localparam int HOLD_CYCLES = 40;   // long receiver hold-off
  localparam int MAX_REPORTS = 10;

  // One result transaction
  typedef struct packed {
    logic [7:0] chr;
    logic       vld;
    logic       lst;
  } char_t;

  // One input byte; when pinned, its single result is given directly
  typedef struct packed {
    logic [7:0] b;
    logic       l;
    logic       pinned;
    char_t      pin;
  } row_t;

  localparam logic [7:0] ESC_CODES [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_LC_B,
                                           CH_LC_F, CH_LC_N, CH_LC_R, CH_LC_T};

  // Directed strings: extremes, escapes, \u groups and the end-of-string cases
  localparam int NUM_DIRECTED = 26;
  localparam row_t DIRECTED [NUM_DIRECTED] = '{
    '{UC_A,      1'b0, 1'b1, '{UC_A,    1'b1, 1'b0}},  // plain pass-through
    '{8'hFF,     1'b0, 1'b1, '{8'hFF,   1'b1, 1'b0}},  // top byte value
    '{CH_NUL,    1'b0, 1'b0, '0},                      // zero byte dropped
    '{CH_BSLASH, 1'b0, 1'b0, '0},
    '{CH_LC_N,   1'b0, 1'b1, '{CH_LF,   1'b1, 1'b0}},
    '{CH_BSLASH, 1'b0, 1'b0, '0},
    '{CH_LC_T,   1'b0, 1'b1, '{CH_TAB,  1'b1, 1'b0}},
    '{CH_BSLASH, 1'b0, 1'b0, '0},
    '{LC_Q,      1'b0, 1'b0, '0},                      // unknown escape, dropped
    '{CH_BSLASH, 1'b0, 1'b0, '0},
    '{CH_LC_U,   1'b0, 1'b0, '0},
    '{UC_F,      1'b0, 1'b0, '0},
    '{LC_F,      1'b0, 1'b0, '0},
    '{UC_F,      1'b0, 1'b0, '0},
    '{UC_F,      1'b0, 1'b0, '0},                      // U+FFFF, three bytes
    '{CH_BSLASH, 1'b0, 1'b0, '0},
    '{CH_LC_U,   1'b0, 1'b0, '0},
    '{DIG_0,     1'b0, 1'b0, '0},
    '{LC_G,      1'b0, 1'b0, '0},                      // non-hex stops the parse
    '{DIG_1,     1'b0, 1'b0, '0},
    '{CH_NUL,    1'b0, 1'b0, '0},                      // code point zero, no output
    '{CH_BSLASH, 1'b0, 1'b0, '0},
    '{CH_LC_U,   1'b0, 1'b0, '0},
    '{UC_D,      1'b1, 1'b1, '{CH_NUL,  1'b0, 1'b1}},  // cut-off \u at end
    '{CH_BSLASH, 1'b1, 1'b1, '{CH_NUL,  1'b0, 1'b1}},  // lone trailing backslash
    '{LC_Z,      1'b1, 1'b1, '{LC_Z,    1'b1, 1'b1}}   // one-byte string
  };

  logic clk;
  logic rst_n;

  jsu_in_if  in_ch ();
  jsu_out_if out_ch ();

  json_string_unescape_top dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Decoder model state
  logic [1:0]  dec_mode;
  logic [1:0]  hex_cnt;
  logic [15:0] cp_acc;
  logic        hex_halt;

  char_t pending_chars [$];   // expected results, oldest first
  row_t  offered_rows [$];    // input bytes in flight, in offer order
  int    fails   = 0;
  int    reports = 0;
  bit    quiet   = 1'b0;      // no idling on either side
  bit    hold_req = 1'b0;     // ask the receiver for a long hold-off
  int    item_cnt = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_decoder();
    dec_mode = MODE_PLAIN;
    hex_cnt  = '0;
    cp_acc   = '0;
    hex_halt = 1'b0;
  endfunction

  // Unescapes one byte; returns how many results it causes (0..3)
  function automatic int decode_byte(input logic [7:0] b, input logic l,
                                     output char_t [2:0] o);
    logic [2:0][7:0] ch;
    logic [3:0]      dv;
    logic            is_hex;
    int              n;
    n  = 0;
    o  = '0;
    ch = '0;
    if (dec_mode == MODE_HEX) begin
      if (!hex_halt) begin
        is_hex = 1'b1;
        dv     = '0;
        if (b >= DIG_0 && b <= DIG_9) dv = 4'(b - DIG_0);
        else if (b >= LC_A && b <= LC_F) dv = 4'(b - LC_A + 8'd10);
        else if (b >= UC_A && b <= UC_F) dv = 4'(b - UC_A + 8'd10);
        else is_hex = 1'b0;
        if (is_hex) cp_acc = {cp_acc[11:0], dv};
        else hex_halt = 1'b1;
      end
      if (hex_cnt == HEX_LAST) begin
        // group complete: UTF-8 encode, zero emits nothing
        if (cp_acc == 16'h0000) begin
          n = 0;
        end else if (cp_acc < 16'h0080) begin
          ch[0] = cp_acc[7:0];
          n = 1;
        end else if (cp_acc < 16'h0800) begin
          ch[0] = {3'b110, cp_acc[10:6]};
          ch[1] = {2'b10, cp_acc[5:0]};
          n = 2;
        end else begin
          ch[0] = {4'b1110, cp_acc[15:12]};
          ch[1] = {2'b10, cp_acc[11:6]};
          ch[2] = {2'b10, cp_acc[5:0]};
          n = 3;
        end
        clear_decoder();
      end else begin
        hex_cnt = hex_cnt + 2'd1;
      end
    end else if (b != CH_NUL) begin
      if (dec_mode == MODE_ESCAPE) begin
        if (b == CH_LC_U) begin
          dec_mode = MODE_HEX;
          hex_cnt  = '0;
          cp_acc   = '0;
          hex_halt = 1'b0;
        end else begin
          n = 1;
          case (b)
            CH_QUOTE, CH_BSLASH, CH_SLASH: ch[0] = b;
            CH_LC_B: ch[0] = CH_BS;
            CH_LC_F: ch[0] = CH_FF;
            CH_LC_N: ch[0] = CH_LF;
            CH_LC_R: ch[0] = CH_CR;
            CH_LC_T: ch[0] = CH_TAB;
            default: n = 0;
          endcase
          dec_mode = MODE_PLAIN;
        end
      end else if (b == CH_BSLASH) begin
        dec_mode = MODE_ESCAPE;
      end else begin
        ch[0] = b;
        n = 1;
      end
    end
    if (l) clear_decoder();
    for (int k = 0; k < n; k++) o[k] = '{ch[k], 1'b1, l && (k == n - 1)};
    // a closing byte with no data still ends the string
    if (n == 0 && l) begin
      o[0] = '{CH_NUL, 1'b0, 1'b1};
      n = 1;
    end
    return n;
  endfunction

  // Monitor: predict on input transactions, check on result transactions
  always @(posedge clk) begin
    row_t       row;
    char_t [2:0] pred;
    char_t      got;
    char_t      want;
    int         n;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        row = offered_rows.pop_front();
        n = decode_byte(in_ch.in_byte, in_ch.in_last, pred);
        if (row.pinned) pending_chars.push_back(row.pin);
        else for (int k = 0; k < n; k++) pending_chars.push_back(pred[k]);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.out_byte, out_ch.out_valid, out_ch.out_last};
        if (pending_chars.size() == 0) begin
          fails++;
          if (reports < MAX_REPORTS) begin
            reports++;
            $display("%0t: unexpected result byte=%h valid=%b last=%b",
                     $realtime, got.chr, got.vld, got.lst);
          end
        end else begin
          want = pending_chars.pop_front();
          if (got != want) begin
            fails++;
            if (reports < MAX_REPORTS) begin
              reports++;
              $display("%0t: expected byte=%h valid=%b last=%b, got byte=%h valid=%b last=%b",
                       $realtime, want.chr, want.vld, want.lst, got.chr, got.vld, got.lst);
            end
          end
        end
      end
    end else begin
      clear_decoder();
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offers one byte, returns at the edge where it is taken
  task automatic send_item(input row_t row);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    offered_rows.push_back(row);
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= row.b;
    in_ch.in_last <= row.l;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // both queues empty: every offered byte taken and every result seen
  task automatic wait_drained();
    while (pending_chars.size() != 0 || offered_rows.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] hex_char(input int v);
    if (v < 10) return DIG_0 + 8'(v);
    return ($urandom_range(0, 1) ? LC_A : UC_A) + 8'(v - 10);
  endfunction

  // Random string: mostly well-formed tokens, some noise, some cut short
  task automatic send_string();
    logic [7:0] s [$];
    logic [7:0] c;
    int         ntok;
    int         kind;
    int         cls;
    int         bad;
    ntok = $urandom_range(1, 8);
    for (int t = 0; t < ntok; t++) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        c = 8'($urandom_range(1, 255));
        if (c == CH_BSLASH) c = UC_A;
        s.push_back(c);
      end else if (kind < 60) begin
        s.push_back(CH_BSLASH);
        s.push_back(ESC_CODES[$urandom_range(0, 7)]);
      end else if (kind < 85) begin
        // \u group: class 0 below 0x100, class 1 below 0x800, class 2 anything
        s.push_back(CH_BSLASH);
        s.push_back(CH_LC_U);
        cls = $urandom_range(0, 2);
        bad = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 3) : -1;
        for (int d = 0; d < 4; d++) begin
          if (d == bad) c = 8'($urandom_range(0, 255));
          else if ((d == 0 && cls < 2) || (d == 1 && cls == 0)) c = DIG_0;
          else if (d == 1 && cls == 1) c = hex_char($urandom_range(0, 7));
          else c = hex_char($urandom_range(0, 15));
          s.push_back(c);
        end
      end else if (kind < 93) begin
        s.push_back(CH_BSLASH);
        s.push_back(8'($urandom_range(0, 255)));
      end else begin
        s.push_back(8'($urandom_range(0, 255)));
      end
    end
    // broken tail: cut up to three bytes; the end may fall in an escape or \u group
    if (s.size() > 1 && $urandom_range(0, 6) == 0)
      repeat ($urandom_range(1, 3)) if (s.size() > 1) void'(s.pop_back());
    foreach (s[i]) begin
      send_item('{s[i], i == s.size() - 1, 1'b0, '0});
      item_cnt++;
    end
  endtask

  // Main sequence
  initial begin
    bit held;
    bit paused;
    held   = 1'b0;
    paused = 1'b0;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= '0;
    in_ch.in_last <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++) send_item(DIRECTED[i]);
    in_ch.valid <= 1'b0;
    wait_drained();

    while (item_cnt < NUM_ITEMS) begin
      if (!held && item_cnt >= NUM_ITEMS / 3) begin
        // receiver blocks while the sender keeps offering: queue fills up
        held = 1'b1;
        hold_req = 1'b1;
      end
      if (!paused && item_cnt >= (2 * NUM_ITEMS) / 3) begin
        paused = 1'b1;
        in_ch.valid <= 1'b0;
        wait_drained();
      end
      if (item_cnt >= NUM_ITEMS - 60) quiet = 1'b1;
      send_string();
    end
    in_ch.valid <= 1'b0;

    wait_drained();
    repeat (10) @(posedge clk);
    if (pending_chars.size() != 0) fails++;
    if (fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #500us;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: sim.f
design/jsu_pkg.sv
design/jsu_in_if.sv
design/jsu_out_if.sv
design/jsu_fifo.sv
design/jsu_front.sv
design/jsu_back.sv
design/json_string_unescape_top.sv
verif/testbench.sv
